// ===== rtl/sliding_window_peak_rate_assert.svh =====
// assertion helpers used by swpr_back
`ifndef SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SWPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SWPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/swpr_pkg.sv =====
package swpr_pkg;

    // field widths
    localparam int TS_W     = 22;
    localparam int CNT_W    = 13;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // time conversion constants
    localparam logic [TS_W-1:0] SECS_PER_DAY  = 22'd86400;
    localparam logic [TS_W-1:0] SECS_PER_HOUR = 22'd3600;
    localparam logic [TS_W-1:0] SECS_PER_MIN  = 22'd60;

    // defaults
    localparam logic [TS_W-1:0] WINDOW_RESET   = 22'd60;
    localparam int              FIFO_DEPTH_DEF = 4096;

    // timestamp transfer between front, queue and back
    typedef struct packed {
        logic            valid;
        logic [TS_W-1:0] stamp;
    } stamp_xfer_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WAIT,
        BK_CHECK
    } back_state_t;

endpackage

// ===== rtl/swpr_front.sv =====
module swpr_front
    import swpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DAY_W-1:0]    s_day,
    input  logic [HOUR_W-1:0]   s_hour,
    input  logic [MINUTE_W-1:0] s_minute,
    input  logic [SECOND_W-1:0] s_second,
    output stamp_xfer_t         q_in,
    input  logic                q_in_ready
);

    logic            stage_valid_reg;
    logic [TS_W-1:0] stage_stamp_reg;
    logic [TS_W-1:0] sum;
    logic [TS_W-1:0] stamp;

    // seconds since month start, saturating at zero for day zero
    always_comb begin
        sum = TS_W'(TS_W'(s_day) * SECS_PER_DAY)
            + TS_W'(TS_W'(s_hour) * SECS_PER_HOUR)
            + TS_W'(TS_W'(s_minute) * SECS_PER_MIN)
            + TS_W'(s_second);
        stamp = (sum >= SECS_PER_DAY) ? (sum - SECS_PER_DAY) : '0;
    end

    assign s_ready = !stage_valid_reg || q_in_ready;

    // one stage register ahead of the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_stamp_reg <= stamp;
        end
    end

    assign q_in.valid = stage_valid_reg;
    assign q_in.stamp = stage_stamp_reg;

endmodule

// ===== rtl/swpr_queue.sv =====
module swpr_queue
    import swpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  stamp_xfer_t q_in,
    output logic        q_in_ready,
    output stamp_xfer_t q_out,
    input  logic        q_out_ready
);

    logic [TS_W-1:0] slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push;
    logic            pop;

    assign q_in_ready  = (count_reg != 2'd2);
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.stamp = slot_reg[rd_ptr_reg];
    assign push        = q_in.valid && q_in_ready;
    assign pop         = q_out.valid && q_out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= q_in.stamp;
        end
    end

endmodule

// ===== rtl/swpr_back.sv =====
`include "sliding_window_peak_rate_assert.svh"
module swpr_back
    import swpr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [TS_W-1:0]  cfg_wr_data,
    input  stamp_xfer_t      q_out,
    output logic             q_out_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CNT_W-1:0] m_window_count,
    output logic [CNT_W-1:0] m_peak_count,
    output logic [TS_W-1:0]  m_peak_start,
    output logic [TS_W-1:0]  m_peak_end,
    output logic             m_overflow
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    back_state_t     state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [CW-1:0]   best_count_reg;
    logic [TS_W-1:0] best_first_reg;
    logic [TS_W-1:0] best_last_reg;
    logic [TS_W-1:0] window_reg;
    logic [TS_W-1:0] stamp_reg;
    logic            ovf_reg;
    logic            mem_we;
    logic [TS_W-1:0] mem [FIFO_DEPTH];
    logic [TS_W-1:0] rd_data_reg;
    logic [TS_W-1:0] win;
    logic [TS_W-1:0] stamp_diff;
    logic            drop;
    logic            finish;
    logic            take;
    logic            m_valid_reg;
    logic [CW-1:0]   wc_reg;
    logic            ovf_out_reg;

    // window length register, zero acts as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    assign win  = (window_reg == '0) ? TS_W'(1) : window_reg;
    assign stamp_diff = (rd_data_reg >= stamp_reg) ? (rd_data_reg - stamp_reg)
                                                   : (stamp_reg - rd_data_reg);
    assign drop = (state_reg == BK_CHECK) && (occ_reg != '0) && (stamp_diff >= win);
    assign finish = (state_reg == BK_CHECK) && !drop && (!m_valid_reg || m_ready);
    assign take = (state_reg == BK_IDLE) && q_out.valid;
    assign q_out_ready = (state_reg == BK_IDLE);

    // sequencer: push, wait for head read, then expire one entry per cycle
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        mem_we     = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_out.valid) begin
                    mem_we    = 1'b1;
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
                    if (occ_reg == FULL_CNT) begin
                        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                    end else begin
                        occ_next = occ_reg + CW'(1);
                    end
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT: begin
                state_next = BK_CHECK;
            end
            BK_CHECK: begin
                if (drop) begin
                    head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                    occ_next  = occ_reg - CW'(1);
                end else if (finish) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            best_count_reg <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            if (finish && (occ_reg > best_count_reg)) begin
                best_count_reg <= occ_reg;
                best_first_reg <= rd_data_reg;
                best_last_reg  <= stamp_reg;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-transaction payload
    always_ff @(posedge aclk) begin
        if (take) begin
            stamp_reg <= q_out.stamp;
            ovf_reg   <= (occ_reg == FULL_CNT);
        end
        if (finish) begin
            wc_reg      <= occ_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // stamp memory, read data always follows the next head
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= q_out.stamp;
        end
        rd_data_reg <= mem[head_next];
    end

    assign m_valid        = m_valid_reg;
    assign m_window_count = CNT_W'(wc_reg);
    assign m_peak_count   = CNT_W'(best_count_reg);
    assign m_peak_start   = best_first_reg;
    assign m_peak_end     = best_last_reg;
    assign m_overflow     = ovf_out_reg;

    `SWPR_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= FULL_CNT, "occupancy above depth")
    `SWPR_ASSERT_NOW(a_new_entry_kept, m_valid_reg, wc_reg != '0, "window count zero")
    `SWPR_ASSERT_NOW(a_peak_covers, m_valid_reg, best_count_reg >= wc_reg, "peak below window")
    `SWPR_ASSERT_NEXT(a_peak_mono, 1'b1, best_count_reg >= $past(best_count_reg), "peak fell")

endmodule

// ===== rtl/sliding_window_peak_rate.sv =====
// Sliding-window peak request rate. Each input transaction carries a request time (day, hour,
// minute, second), converted to seconds since month start and stored in a stamp memory of
// FIFO_DEPTH entries; entries whose distance from the new time reaches window_seconds (zero acts
// as one) are expired from the head, and one result transaction reports the window count, the
// peak count since reset with its first and last times, and an overflow flag when a full memory
// dropped its oldest entry. The back end takes a transaction through its idle, wait and check
// states and takes no new one until done; in check, the single read port of the stamp memory
// tests one head entry a cycle. A front stage and a two-entry queue keep accepting transactions
// while the back end works or a result waits. The user must write window_seconds through
// cfg_wr_en/cfg_wr_data only while idle; the block itself does not enforce this.
module sliding_window_peak_rate
    import swpr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [TS_W-1:0]     cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DAY_W-1:0]    s_day,
    input  logic [HOUR_W-1:0]   s_hour,
    input  logic [MINUTE_W-1:0] s_minute,
    input  logic [SECOND_W-1:0] s_second,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CNT_W-1:0]    m_window_count,
    output logic [CNT_W-1:0]    m_peak_count,
    output logic [TS_W-1:0]     m_peak_start,
    output logic [TS_W-1:0]     m_peak_end,
    output logic                m_overflow
);

    stamp_xfer_t q_in;
    stamp_xfer_t q_out;
    logic        q_in_ready;
    logic        q_out_ready;

    // accept and convert
    swpr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_day      (s_day),
        .s_hour     (s_hour),
        .s_minute   (s_minute),
        .s_second   (s_second),
        .q_in       (q_in),
        .q_in_ready (q_in_ready)
    );

    // decoupling queue
    swpr_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_in        (q_in),
        .q_in_ready  (q_in_ready),
        .q_out       (q_out),
        .q_out_ready (q_out_ready)
    );

    // window engine
    swpr_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_out          (q_out),
        .q_out_ready    (q_out_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_count (m_window_count),
        .m_peak_count   (m_peak_count),
        .m_peak_start   (m_peak_start),
        .m_peak_end     (m_peak_end),
        .m_overflow     (m_overflow)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import swpr_pkg::*;

    localparam int DEPTH        = FIFO_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int MAX_STAMP    = 2678399;
    localparam int WINDOW_MAX   = 2678400;
    localparam int MAX_PRINTS   = 40;
    localparam int SETTLE_TICKS = 16;

    // one expected result transaction
    typedef struct packed {
        logic [CNT_W-1:0] window_count;
        logic [CNT_W-1:0] peak_count;
        logic [TS_W-1:0]  peak_start;
        logic [TS_W-1:0]  peak_end;
        logic             overflow;
    } peak_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [TS_W-1:0]     cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [DAY_W-1:0]    s_day = 5'd1;
    logic [HOUR_W-1:0]   s_hour = '0;
    logic [MINUTE_W-1:0] s_minute = '0;
    logic [SECOND_W-1:0] s_second = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CNT_W-1:0]    m_window_count;
    logic [CNT_W-1:0]    m_peak_count;
    logic [TS_W-1:0]     m_peak_start;
    logic [TS_W-1:0]     m_peak_end;
    logic                m_overflow;

    sliding_window_peak_rate #(.FIFO_DEPTH(DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_day          (s_day),
        .s_hour         (s_hour),
        .s_minute       (s_minute),
        .s_second       (s_second),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_count (m_window_count),
        .m_peak_count   (m_peak_count),
        .m_peak_start   (m_peak_start),
        .m_peak_end     (m_peak_end),
        .m_overflow     (m_overflow)
    );

    // shadow of the block state
    logic [TS_W-1:0] stamp_mem [DEPTH];
    int unsigned     head_ptr = 0;
    int unsigned     tail_ptr = 0;
    int unsigned     live_count = 0;
    int unsigned     best_count = 0;
    logic [TS_W-1:0] best_first = '0;
    logic [TS_W-1:0] best_last = '0;
    logic [TS_W-1:0] window_len = WINDOW_RESET;

    peak_result_t expected_q[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int stamps_sent = 0;
    int results_seen = 0;
    int overflows_seen = 0;
    int unsigned cur_stamp = 0;

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d, result %0d: %s got %0d want %0d",
                     cycle_count, results_seen, what, got, want);
        mismatches++;
    endtask

    // window update for one request time, mirrors the block
    function automatic peak_result_t predict_peak(input logic [DAY_W-1:0] d,
                                                  input logic [HOUR_W-1:0] h,
                                                  input logic [MINUTE_W-1:0] mi,
                                                  input logic [SECOND_W-1:0] se);
        int unsigned  sum;
        int unsigned  t;
        int unsigned  win;
        int unsigned  oldest;
        int unsigned  stamp_diff;
        peak_result_t r;
        sum = int'(d) * int'(SECS_PER_DAY) + int'(h) * int'(SECS_PER_HOUR)
            + int'(mi) * int'(SECS_PER_MIN) + int'(se);
        t = (sum >= int'(SECS_PER_DAY)) ? sum - int'(SECS_PER_DAY) : 0;
        t = t & 32'h3FFFFF;
        win = (window_len == 0) ? 1 : int'(window_len);
        r.overflow = 1'b0;
        // full store drops its oldest entry first
        if (live_count >= DEPTH) begin
            head_ptr = (head_ptr + 1) % DEPTH;
            live_count--;
            r.overflow = 1'b1;
        end
        stamp_mem[tail_ptr] = t[TS_W-1:0];
        tail_ptr = (tail_ptr + 1) % DEPTH;
        live_count++;
        // expire head entries by absolute distance
        while (live_count > 0) begin
            oldest = stamp_mem[head_ptr];
            stamp_diff = (oldest >= t) ? oldest - t : t - oldest;
            if (stamp_diff < win)
                break;
            head_ptr = (head_ptr + 1) % DEPTH;
            live_count--;
        end
        if (live_count > best_count) begin
            best_count = live_count;
            best_first = stamp_mem[head_ptr];
            best_last = t[TS_W-1:0];
        end
        r.window_count = live_count[CNT_W-1:0];
        r.peak_count = best_count[CNT_W-1:0];
        r.peak_start = best_first;
        r.peak_end = best_last;
        return r;
    endfunction

    // offer one request transaction, called at a rising edge
    task automatic send_stamp(input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
                              input logic [MINUTE_W-1:0] mi, input logic [SECOND_W-1:0] se);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_day <= d;
        s_hour <= h;
        s_minute <= mi;
        s_second <= se;
        // ready is stable between the falling edge and the next rising edge
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        expected_q.push_back(predict_peak(d, h, mi, se));
        stamps_sent++;
    endtask

    // offer a time given as seconds since month start
    task automatic send_time(input int unsigned t);
        int unsigned s;
        s = t + 86400;
        send_stamp(DAY_W'(s / 86400), HOUR_W'((s % 86400) / 3600),
                   MINUTE_W'((s % 3600) / 60), SECOND_W'(s % 60));
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_window(input logic [TS_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window_len = value;
    endtask

    // result checker, sampled at the falling edge ahead of the transfer edge
    always @(negedge aclk) begin : check_results
        peak_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_overflow === 1'b1)
                overflows_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, window_count", m_window_count, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_window_count !== want.window_count)
                    report_mismatch("window_count", m_window_count, want.window_count);
                if (m_peak_count !== want.peak_count)
                    report_mismatch("peak_count", m_peak_count, want.peak_count);
                if (m_peak_start !== want.peak_start)
                    report_mismatch("peak_start", m_peak_start, want.peak_start);
                if (m_peak_end !== want.peak_end)
                    report_mismatch("peak_end", m_peak_end, want.peak_end);
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", m_overflow, want.overflow);
            end
        end
    end

    // edges of the fields, day zero, out of range fields, zero and extreme windows
    task automatic test_directed_cases();
        idle_pct = 0;
        stall_pct = 0;
        // reset window of 60 seconds
        send_time(0);
        send_time(30);
        send_time(59);
        send_time(60);
        send_time(10);
        send_time(MAX_STAMP);
        send_stamp(5'd0, 5'd23, 6'd59, 6'd59);
        send_stamp(5'd0, 5'd0, 6'd0, 6'd0);
        send_stamp(5'd31, 5'd31, 6'd63, 6'd63);
        send_stamp(5'd31, 5'd0, 6'd0, 6'd0);
        send_stamp(5'd1, 5'd31, 6'd63, 6'd63);
        // zero window acts as one second
        write_window('0);
        send_time(500);
        send_time(500);
        send_time(500);
        send_time(501);
        write_window(22'd1);
        send_time(501);
        send_time(501);
        // widest window
        write_window(TS_W'(WINDOW_MAX));
        send_time(0);
        send_time(MAX_STAMP);
        send_time(1339200);
        send_stamp(5'd31, 5'd31, 6'd63, 6'd63);
    endtask

    // mostly ordered request streams with some back steps and raw noise
    task automatic run_random_phase(input int count, input logic [TS_W-1:0] win,
                                    input int idle, input int stall);
        int unsigned step_max;
        int unsigned back;
        int          kind;
        write_window(win);
        idle_pct = idle;
        stall_pct = stall;
        step_max = (win / 6 > 0) ? win / 6 : 1;
        cur_stamp = $urandom_range(0, MAX_STAMP);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                cur_stamp = cur_stamp + $urandom_range(0, step_max);
                if (cur_stamp > MAX_STAMP)
                    cur_stamp = $urandom_range(0, 100000);
                send_time(cur_stamp);
            end else if (kind < 90) begin
                back = $urandom_range(0, 2 * step_max + 2);
                cur_stamp = (cur_stamp > back) ? cur_stamp - back : 0;
                send_time(cur_stamp);
            end else begin
                send_stamp(DAY_W'($urandom), HOUR_W'($urandom), MINUTE_W'($urandom),
                           SECOND_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(250, 22'd60, 0, 0);
        run_random_phase(250, 22'd1, 72, 0);
        run_random_phase(250, 22'd3600, 0, 72);
        run_random_phase(250, '0, 33, 33);
        run_random_phase(250, TS_W'(WINDOW_MAX), 33, 33);
    endtask

    // build a deep window under a full month, then sweep it in one request
    task automatic test_deep_fill();
        write_window(TS_W'(WINDOW_MAX));
        idle_pct = 0;
        stall_pct = 33;
        for (int i = 0; i < 320; i++)
            send_time(i / 2);
        // one far request then sweeps the whole store
        write_window(22'd3000);
        send_time(5000);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_deep_fill();
        drain_results();
        $display("sent %0d request transactions, checked %0d results, %0d with overflow",
                 stamps_sent, results_seen, overflows_seen);
        $display("windows 0, 1, 60, 3600 and full month, with and without idling on both sides");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
